>>> design/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

  // Table geometry.
  localparam int ENTRIES     = 16;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BYTES = 8;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = 5;
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int OP_W        = 2;
  localparam int ST_W        = 3;

  // Command opcodes.
  localparam logic [OP_W-1:0] OP_SET = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL = 2'd1;
  localparam logic [OP_W-1:0] OP_GET = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [ST_W-1:0] ST_DROPPED  = 3'd2;
  localparam logic [ST_W-1:0] ST_DELETED  = 3'd3;
  localparam logic [ST_W-1:0] ST_ABSENT   = 3'd4;
  localparam logic [ST_W-1:0] ST_HIT      = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] entries_used;
  } out_item_t;

  // Keep at most nbytes bytes of the word and clear everything from the
  // first zero byte on.
  function automatic logic [63:0] as_string(input logic [63:0] word, input int nbytes);
    logic [63:0] res;
    logic        alive;
    res   = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i >= nbytes || word[8*i +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      if (alive) begin
        res[8*i +: 8] = word[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/kvt_ram.sv
`default_nettype none

module kvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/key_value_table_engine_core.sv
`default_nettype none

// An item's scan ends at the first matching slot or after the last filled slot,
// and is skipped with an empty table. Throughput: one item at a time; the next
// item is accepted only once the last has been applied, as the single key compare
// walks the stored slots one per cycle, and a result that is not taken holds up
// the apply step. Reset: synchronous, active low; clears the control registers,
// among them the valid marks and fill count; payload registers are not reset.
module key_value_table_engine_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire kvt_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kvt_pkg::out_item_t     out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;

  // Control state.
  logic [1:0]                    state_r, state_nxt;
  logic [kvt_pkg::ENTRIES-1:0]   valid_r, valid_nxt;
  logic [kvt_pkg::CNT_W-1:0]     fill_r, fill_nxt;
  logic [kvt_pkg::IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [kvt_pkg::IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                          chk_r, chk_nxt;
  logic                          found_r, found_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Payload state.
  logic [kvt_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [kvt_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [kvt_pkg::VAL_W-1:0]     val_r, val_nxt;
  logic [kvt_pkg::IDX_W-1:0]     slot_r, slot_nxt;
  logic [kvt_pkg::VAL_W-1:0]     rdv_r, rdv_nxt;
  kvt_pkg::out_item_t            out_item_r, out_item_nxt;

  // Memory ports.
  logic                          key_we;
  logic                          val_we;
  logic [kvt_pkg::IDX_W-1:0]     wr_addr;
  logic [kvt_pkg::KEY_W-1:0]     key_rdata;
  logic [kvt_pkg::VAL_W-1:0]     val_rdata;

  logic                          in_acc;
  logic                          out_free;
  logic                          hit;
  logic                          last;

  kvt_ram #(
    .WIDTH(kvt_pkg::KEY_W),
    .DEPTH(kvt_pkg::ENTRIES)
  ) u_key_ram (
    .clk    (clk),
    .wr_en  (key_we),
    .wr_addr(wr_addr),
    .wr_data(key_r),
    .rd_addr(rd_idx_r),
    .rd_data(key_rdata)
  );

  kvt_ram #(
    .WIDTH(kvt_pkg::VAL_W),
    .DEPTH(kvt_pkg::ENTRIES)
  ) u_val_ram (
    .clk    (clk),
    .wr_en  (val_we),
    .wr_addr(wr_addr),
    .wr_data(val_r),
    .rd_addr(rd_idx_r),
    .rd_data(val_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Compare of the slot whose key arrived from the memory this cycle.
  assign hit  = chk_r && valid_r[chk_idx_r] && (key_rdata == key_r);
  assign last = chk_r &&
                (({1'b0, chk_idx_r} + kvt_pkg::CNT_W'(1)) == fill_r);

  // Sequencer: accept, scan the filled slots, then apply and report.
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_nxt       = chk_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    slot_nxt      = slot_r;
    rdv_nxt       = rdv_r;
    out_item_nxt  = out_item_r;
    key_we        = 1'b0;
    val_we        = 1'b0;
    wr_addr       = slot_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_item.opcode;
          key_nxt    = kvt_pkg::as_string(in_item.key, kvt_pkg::KEY_BYTES);
          val_nxt    = kvt_pkg::as_string(in_item.value, kvt_pkg::VALUE_BYTES);
          rd_idx_nxt = '0;
          chk_nxt    = 1'b0;
          found_nxt  = 1'b0;
          state_nxt  = (fill_r == '0) ? S_ACT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = chk_idx_r;
          rdv_nxt   = val_rdata;
          state_nxt = S_ACT;
        end else if (last) begin
          found_nxt = 1'b0;
          state_nxt = S_ACT;
        end else begin
          chk_nxt     = 1'b1;
          chk_idx_nxt = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + kvt_pkg::IDX_W'(1);
        end
      end
      S_ACT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.status     = kvt_pkg::ST_ABSENT;
          out_item_nxt.read_value = '0;
          case (op_r)
            kvt_pkg::OP_SET: begin
              if (found_r) begin
                val_we              = 1'b1;
                out_item_nxt.status = kvt_pkg::ST_UPDATED;
              end else if (fill_r < kvt_pkg::CNT_W'(kvt_pkg::ENTRIES)) begin
                wr_addr                         = fill_r[kvt_pkg::IDX_W-1:0];
                key_we                          = 1'b1;
                val_we                          = 1'b1;
                valid_nxt[fill_r[kvt_pkg::IDX_W-1:0]] = 1'b1;
                fill_nxt                        = fill_r + kvt_pkg::CNT_W'(1);
                out_item_nxt.status             = kvt_pkg::ST_INSERTED;
              end else begin
                out_item_nxt.status = kvt_pkg::ST_DROPPED;
              end
            end
            kvt_pkg::OP_DEL: begin
              if (found_r) begin
                valid_nxt[slot_r]   = 1'b0;
                out_item_nxt.status = kvt_pkg::ST_DELETED;
              end
            end
            kvt_pkg::OP_GET: begin
              if (found_r) begin
                out_item_nxt.status     = kvt_pkg::ST_HIT;
                out_item_nxt.read_value = rdv_r;
              end
            end
            default: begin
              out_item_nxt.status = kvt_pkg::ST_ABSENT;
            end
          endcase
          out_item_nxt.entries_used = fill_nxt;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      chk_idx_r   <= '0;
      chk_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      chk_r       <= chk_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    slot_r     <= slot_nxt;
    rdv_r      <= rdv_nxt;
    out_item_r <= out_item_nxt;
  end

  // The fill count never passes the table size.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= kvt_pkg::CNT_W'(kvt_pkg::ENTRIES))
    else $error("fill count beyond table size");

  // No slot at or beyond the fill count is ever marked valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r >> fill_r) == '0)
    else $error("valid mark beyond fill count");

  // An accepted item leaves the sequencer busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN || state_r == S_ACT))
    else $error("accepted item not processed");

  // A result is only loaded from the apply step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_ACT)
    else $error("result raised outside apply step");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Opcode three has no meaning; the block must answer it as an absent key.
  localparam logic [kvt_pkg::OP_W-1:0] OP_NONE = 2'd3;

  localparam int POOL_SIZE    = 20;
  localparam int RANDOM_ITEMS = 1130;
  localparam int PHASE_LEN    = 400;
  localparam int HOLD_AT      = 900;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  kvt_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  kvt_pkg::out_item_t out_item;

  // Commands still to be offered, and the replies the table owes.
  kvt_pkg::in_item_t  commands_waiting [$];
  kvt_pkg::out_item_t replies_due [$];

  int commands_offered = 0;
  int commands_taken = 0;
  int mismatches = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  // Shadow copy of the table.
  logic [kvt_pkg::KEY_W-1:0] table_keys [kvt_pkg::ENTRIES];
  logic [kvt_pkg::VAL_W-1:0] table_values [kvt_pkg::ENTRIES];
  logic                      table_live [kvt_pkg::ENTRIES] = '{default: 1'b0};
  int                        table_fill = 0;

  key_value_table_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  // A key or value ends at its first zero byte and holds at most nbytes bytes.
  function automatic logic [63:0] clip_string(logic [63:0] word, int nbytes);
    int len;
    len = 0;
    while (len < nbytes && len < 8 && word[8*len +: 8] != 8'h00) len++;
    if (len == 8) begin
      return word;
    end
    return word & ((64'h1 << (8 * len)) - 64'h1);
  endfunction

  // Applies one command to the shadow table and returns the reply it causes.
  function automatic kvt_pkg::out_item_t apply_command(kvt_pkg::in_item_t cmd);
    kvt_pkg::out_item_t        reply;
    logic [kvt_pkg::KEY_W-1:0] key;
    logic [kvt_pkg::VAL_W-1:0] val;
    int                        slot;
    key = clip_string(cmd.key, kvt_pkg::KEY_BYTES);
    val = clip_string(cmd.value, kvt_pkg::VALUE_BYTES);
    slot = -1;
    for (int i = 0; i < table_fill && i < kvt_pkg::ENTRIES; i++) begin
      if (slot < 0 && table_live[i] && table_keys[i] == key) slot = i;
    end
    reply.status = kvt_pkg::ST_ABSENT;
    reply.read_value = '0;
    case (cmd.opcode)
      kvt_pkg::OP_SET: begin
        if (slot >= 0) begin
          table_values[slot] = val;
          reply.status = kvt_pkg::ST_UPDATED;
        end else if (table_fill < kvt_pkg::ENTRIES) begin
          table_keys[table_fill] = key;
          table_values[table_fill] = val;
          table_live[table_fill] = 1'b1;
          table_fill++;
          reply.status = kvt_pkg::ST_INSERTED;
        end else begin
          reply.status = kvt_pkg::ST_DROPPED;
        end
      end
      kvt_pkg::OP_DEL: begin
        if (slot >= 0) begin
          table_live[slot] = 1'b0;
          reply.status = kvt_pkg::ST_DELETED;
        end
      end
      kvt_pkg::OP_GET: begin
        if (slot >= 0) begin
          reply.read_value = table_values[slot];
          reply.status = kvt_pkg::ST_HIT;
        end
      end
      default: begin
      end
    endcase
    reply.entries_used = kvt_pkg::CNT_W'(table_fill);
    return reply;
  endfunction

  // Idle rates per phase: sender light and receiver heavy, then swapped, then none.
  function automatic int send_idle_pct();
    if (commands_taken < PHASE_LEN) return 11;
    if (commands_taken < 2 * PHASE_LEN) return 83;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (commands_taken < PHASE_LEN) return 83;
    if (commands_taken < 2 * PHASE_LEN) return 11;
    return 0;
  endfunction

  // A string of len nonzero random bytes.
  function automatic logic [63:0] random_string(int len);
    logic [63:0] word;
    word = '0;
    for (int i = 0; i < len; i++) word[8*i +: 8] = 8'($urandom_range(255, 1));
    return word;
  endfunction

  // Sometimes fills the bytes past the terminating zero with junk.
  function automatic logic [63:0] dress_string(logic [63:0] base, int len);
    logic [63:0] word;
    word = base;
    if (len < 7 && $urandom_range(1) == 1) begin
      for (int i = len + 1; i < 8; i++) word[8*i +: 8] = 8'($urandom);
    end
    return word;
  endfunction

  task automatic queue_command(logic [kvt_pkg::OP_W-1:0] op, logic [63:0] key,
                               logic [63:0] value);
    kvt_pkg::in_item_t cmd;
    cmd.opcode = op;
    cmd.key = key;
    cmd.value = value;
    commands_waiting.push_back(cmd);
  endtask

  // Driver: offers the next command once the previous one has been taken.
  always @(negedge clk) begin : drive_proc
    kvt_pkg::in_item_t next_cmd;
    logic              next_valid;
    next_cmd = in_item;
    next_valid = in_valid;
    if (rst_n && commands_taken == commands_offered) begin
      next_valid = 1'b0;
      if (commands_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        next_cmd = commands_waiting.pop_front();
        next_valid = 1'b1;
        commands_offered++;
      end
    end
    in_valid <= next_valid;
    in_item <= next_cmd;
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk) begin : stall_proc
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && commands_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct());
    end
  end

  // Monitor: checks each reply against the oldest due one, then records new commands.
  always @(posedge clk) begin : watch_proc
    kvt_pkg::out_item_t due;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("reply with no command outstanding: status %0d", out_item.status);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          if (out_item.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_item.status);
            mismatches++;
          end
          if (out_item.read_value !== due.read_value) begin
            $error("read_value: expected %h, got %h", due.read_value, out_item.read_value);
            mismatches++;
          end
          if (out_item.entries_used !== due.entries_used) begin
            $error("entries_used: expected %0d, got %0d", due.entries_used,
                   out_item.entries_used);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        replies_due.push_back(apply_command(in_item));
        commands_taken++;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : main_proc
    logic [63:0] pool_keys [POOL_SIZE];
    int          pool_lens [POOL_SIZE];
    logic [63:0] pool_word;
    logic [63:0] noise_word;
    logic [63:0] val;
    int          slot;
    int          len;
    int          pick;
    int          useful;

    // Directed: empty table, the empty key, junk past the terminator, update,
    // opcode three, delete and re-insert, extreme bit patterns.
    queue_command(kvt_pkg::OP_GET, 64'h0, 64'h0);
    queue_command(kvt_pkg::OP_DEL, 64'h41, 64'h0);
    queue_command(OP_NONE, 64'h0, {64{1'b1}});
    queue_command(kvt_pkg::OP_SET, 64'h0, {64{1'b1}});
    queue_command(kvt_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FF00, 64'h0);
    queue_command(kvt_pkg::OP_SET, {64{1'b1}}, 64'h1);
    queue_command(kvt_pkg::OP_GET, {64{1'b1}}, 64'h0);
    queue_command(kvt_pkg::OP_SET, 64'h1234_5678_0000_0041, 64'hAB00_1234_5600_7F7F);
    queue_command(kvt_pkg::OP_GET, 64'h41, 64'h0);
    queue_command(kvt_pkg::OP_SET, 64'h41, 64'h8000_0000_0000_0000);
    queue_command(kvt_pkg::OP_GET, 64'hFF00_0000_0000_0041, 64'h0);
    queue_command(OP_NONE, 64'h41, {64{1'b1}});
    queue_command(kvt_pkg::OP_GET, 64'h41, 64'h0);
    queue_command(kvt_pkg::OP_DEL, 64'h0, 64'h0);
    queue_command(kvt_pkg::OP_GET, 64'h0, 64'h0);
    queue_command(kvt_pkg::OP_DEL, 64'h0, 64'h0);
    queue_command(kvt_pkg::OP_SET, 64'h0, 64'h0102_0304_0506_0708);
    queue_command(kvt_pkg::OP_GET, 64'h0, 64'h0);
    queue_command(kvt_pkg::OP_SET, 64'h8080_8080_8080_8080, {64{1'b1}});
    queue_command(kvt_pkg::OP_GET, 64'h7F7F_7F7F_7F7F_7F7F, 64'h0);
    queue_command(kvt_pkg::OP_DEL, {64{1'b1}}, 64'h0);
    queue_command(kvt_pkg::OP_SET, {64{1'b1}}, 64'h5);

    // Random: mostly commands on a small pool of keys so that updates and hits are
    // common and deletes rarer; the pool is larger than the table, so it fills up.
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_lens[i] = $urandom_range(8);
      pool_keys[i] = random_string(pool_lens[i]);
    end
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      slot = $urandom_range(POOL_SIZE - 1);
      pool_word = dress_string(pool_keys[slot], pool_lens[slot]);
      noise_word = {$urandom, $urandom};
      len = $urandom_range(8);
      val = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                     : dress_string(random_string(len), len);
      pick = $urandom_range(99);
      if (pick < 40) begin
        queue_command(kvt_pkg::OP_SET, ($urandom_range(9) == 0) ? noise_word : pool_word,
                      val);
        useful++;
      end else if (pick < 88) begin
        queue_command(kvt_pkg::OP_GET, ($urandom_range(6) == 0) ? noise_word : pool_word,
                      val);
        useful++;
      end else if (pick < 89) begin
        queue_command(kvt_pkg::OP_DEL, pool_word, val);
        useful++;
      end else if (pick < 95) begin
        queue_command(kvt_pkg::OP_DEL, noise_word, val);
        useful++;
      end else begin
        queue_command(OP_NONE, ($urandom_range(1) == 0) ? noise_word : pool_word, val);
        useful++;
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (commands_waiting.size() != 0 || commands_taken != commands_offered) begin
      @(posedge clk);
    end
    while (replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("key_value_table_engine_core test passed");
    end else begin
      $display("key_value_table_engine_core test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog_proc
    #4_000_000;
    $display("key_value_table_engine_core test failed");
    $finish;
  end

endmodule
